/* design/cbcp_pkg.sv */
// ---------------------------------------------------------------------------
// cbcp_pkg: shared types and constants
// Shared definitions for the circle versus box pushout block.
// ---------------------------------------------------------------------------
package cbcp_pkg;

  localparam int CoordW   = 24;
  localparam int RegW     = 15;
  localparam int FracBits = 12;

  localparam logic [15:0] One     = 16'(1 << FracBits);
  localparam logic [15:0] EpsDist = 16'(((1 << FracBits) + 500) / 1000);
  localparam logic [16:0] EpsPush = 17'(((1 << FracBits) * 5 + 500) / 1000);

  localparam logic [RegW-1:0] RadiusReset     = 15'd1638;
  localparam logic [RegW-1:0] HalfHeightReset = 15'd3686;

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic {
    REG_RADIUS      = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic                     solid;
  } box_t;

endpackage

/* design/circle_box_collision_pushout_top.sv */
// ---------------------------------------------------------------------------
// circle_box_collision_pushout_top: circle versus box pushout
// Box table in one synchronous memory, walked box by box on each resolve.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Moves
//  in       in_valid / in_ready    load, resolve or clear operation
//  out      out_valid / out_ready  resolved position, one per resolve
//  cfg      cfg_valid / cfg_ready  radius and half height registers
//
// Load, clear and unused operations finish without leaving the idle state. A
// resolve walks every stored box in turn: a box that is not solid is skipped,
// one that misses goes no further than the distance test, and one that pushes
// runs the square root and the two parallel dividers, which set its cost.
// Reset clears the box count and overflow flag and resets the registers; the
// memory needs no clearing. A stalled result holds in the output register.
// ---------------------------------------------------------------------------
module circle_box_collision_pushout_top #(
  parameter int MAX_BOXES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [23:0] box_min_x,
  input  logic signed [23:0] box_min_y,
  input  logic signed [23:0] box_min_z,
  input  logic signed [23:0] box_max_x,
  input  logic signed [23:0] box_max_y,
  input  logic signed [23:0] box_max_z,
  input  logic               box_solid,
  input  logic signed [23:0] player_x,
  input  logic signed [23:0] player_y,
  input  logic signed [23:0] player_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] resolved_x,
  output logic signed [23:0] resolved_z,
  output logic               any_push,
  output logic               table_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_addr,
  input  logic [14:0]        cfg_data
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_R2    = 13'b0000000000010,
    S_READ  = 13'b0000000000100,
    S_CLAMP = 13'b0000000001000,
    S_SQX   = 13'b0000000010000,
    S_SQZ   = 13'b0000000100000,
    S_TEST  = 13'b0000001000000,
    S_SQRT  = 13'b0000010000000,
    S_PMX   = 13'b0000100000000,
    S_PMZ   = 13'b0001000000000,
    S_DIVS  = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t state;

  cbcp_pkg::box_t box_mem [MAX_BOXES];
  cbcp_pkg::box_t rd_box;

  logic [14:0] radius;
  logic [14:0] half_height;
  logic [CW-1:0] box_count;
  logic          overflow_flag;
  logic [AW-1:0] idx;

  logic signed [23:0] px, py, pz;
  logic signed [24:0] dx, dz;
  logic               y_ok;
  logic [29:0] r2;
  logic [30:0] sqx;
  logic [31:0] d2;
  logic        fits16;
  logic signed [16:0] ex, ez, push;
  logic [15:0] divisor;
  logic signed [33:0] prod_x, prod_z;
  logic        pushed;

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  logic        sqrt_start, sqrt_done, div_start, div_done, div_z_done;
  logic [15:0] root;
  logic signed [33:0] quo_x, quo_z;

  logic signed [23:0] cx_t, cx, cz_t, cz;
  logic signed [25:0] y_lo, y_hi;
  logic [CW-1:0] idx_inc;
  logic signed [34:0] sum_x, sum_z;
  logic signed [23:0] sat_x, sat_z;
  logic in_acc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  cbcp_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (d2),
    .done     (sqrt_done),
    .root     (root)
  );

  cbcp_div #(.NW(34), .DW(16)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_x),
    .den   (divisor),
    .done  (div_done),
    .quo   (quo_x)
  );

  // Both dividers start together and run the same number of cycles.
  cbcp_div #(.NW(34), .DW(16)) u_div_z (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_z),
    .den   (divisor),
    .done  (div_z_done),
    .quo   (quo_z)
  );

  always_comb begin
    // Upper bound first, then lower, so an inverted box yields its lower corner.
    cx_t = (px > rd_box.max_x) ? rd_box.max_x : px;
    cx   = (cx_t < rd_box.min_x) ? rd_box.min_x : cx_t;
    cz_t = (pz > rd_box.max_z) ? rd_box.max_z : pz;
    cz   = (cz_t < rd_box.min_z) ? rd_box.min_z : cz_t;
    y_lo = 26'(py) - $signed({11'b0, half_height});
    y_hi = 26'(py) + $signed({11'b0, half_height});
    idx_inc = CW'(idx) + CW'(1);

    case (state)
      S_R2: begin
        mul_a = $signed({2'b0, radius});
        mul_b = $signed({2'b0, radius});
      end
      S_SQX: begin
        mul_a = {dx[15], dx[15:0]};
        mul_b = {dx[15], dx[15:0]};
      end
      S_SQZ: begin
        mul_a = {dz[15], dz[15:0]};
        mul_b = {dz[15], dz[15:0]};
      end
      S_PMX: begin
        mul_a = ex;
        mul_b = push;
      end
      S_PMZ: begin
        mul_a = ez;
        mul_b = push;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;

    sum_x = 35'(px) + 35'(quo_x);
    sum_z = 35'(pz) + 35'(quo_z);
    if (sum_x > 35'(cbcp_pkg::CoordMax)) sat_x = cbcp_pkg::CoordMax;
    else if (sum_x < 35'(cbcp_pkg::CoordMin)) sat_x = cbcp_pkg::CoordMin;
    else sat_x = sum_x[23:0];
    if (sum_z > 35'(cbcp_pkg::CoordMax)) sat_z = cbcp_pkg::CoordMax;
    else if (sum_z < 35'(cbcp_pkg::CoordMin)) sat_z = cbcp_pkg::CoordMin;
    else sat_z = sum_z[23:0];

    sqrt_start = 1'b0;
    div_start  = (state == S_DIVS);
    if (state == S_TEST) begin
      sqrt_start = fits16 && (d2 < {2'b0, r2}) && y_ok;
    end
  end

  // Box table: written on load, read once per box during a resolve.
  always_ff @(posedge clk) begin
    if (in_acc && operation == cbcp_pkg::OP_LOAD && box_count < CW'(MAX_BOXES)) begin
      box_mem[box_count[AW-1:0]] <= '{box_min_x, box_min_y, box_min_z,
                                      box_max_x, box_max_y, box_max_z, box_solid};
    end
    if (state == S_READ) begin
      rd_box <= box_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      radius        <= cbcp_pkg::RadiusReset;
      half_height   <= cbcp_pkg::HalfHeightReset;
      box_count     <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
      idx           <= '0;
      pushed        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          cbcp_pkg::REG_RADIUS:      radius      <= cfg_data;
          cbcp_pkg::REG_HALF_HEIGHT: half_height <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (operation)
              cbcp_pkg::OP_LOAD: begin
                if (box_count < CW'(MAX_BOXES)) box_count <= box_count + CW'(1);
                else overflow_flag <= 1'b1;
              end
              cbcp_pkg::OP_CLEAR: box_count <= '0;
              cbcp_pkg::OP_RESOLVE: begin
                px     <= player_x;
                py     <= player_y;
                pz     <= player_z;
                idx    <= '0;
                pushed <= 1'b0;
                state  <= S_R2;
              end
              default: ;
            endcase
          end
        end
        S_R2: begin
          r2    <= mul_p[29:0];
          state <= (box_count == '0) ? S_EMIT : S_READ;
        end
        S_READ: state <= S_CLAMP;
        S_CLAMP: begin
          dx   <= 25'(px) - 25'(cx);
          dz   <= 25'(pz) - 25'(cz);
          y_ok <= (y_lo < 26'(rd_box.max_y)) && (y_hi > 26'(rd_box.min_y));
          if (rd_box.solid) begin
            state <= S_SQX;
          end else if (idx_inc == box_count) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx_inc[AW-1:0];
            state <= S_READ;
          end
        end
        S_SQX: begin
          sqx    <= mul_p[30:0];
          fits16 <= (dx[24:15] == {10{dx[15]}}) && (dz[24:15] == {10{dz[15]}});
          state  <= S_SQZ;
        end
        S_SQZ: begin
          d2    <= {1'b0, sqx} + mul_p[31:0];
          state <= S_TEST;
        end
        S_TEST: begin
          if (sqrt_start) begin
            state <= S_SQRT;
          end else if (idx_inc == box_count) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx_inc[AW-1:0];
            state <= S_READ;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            // A near-zero distance pushes along plus x as if at unit distance.
            if (root < cbcp_pkg::EpsDist) begin
              ex      <= $signed({1'b0, cbcp_pkg::One});
              ez      <= '0;
              divisor <= cbcp_pkg::One;
              push    <= $signed({2'b0, radius}) + cbcp_pkg::EpsPush
                         - $signed({1'b0, cbcp_pkg::One});
            end else begin
              ex      <= {dx[15], dx[15:0]};
              ez      <= {dz[15], dz[15:0]};
              divisor <= root;
              push    <= $signed({2'b0, radius}) + cbcp_pkg::EpsPush
                         - $signed({1'b0, root});
            end
            state <= S_PMX;
          end
        end
        S_PMX: begin
          prod_x <= mul_p;
          state  <= S_PMZ;
        end
        S_PMZ: begin
          prod_z <= mul_p;
          state  <= S_DIVS;
        end
        S_DIVS: state <= S_DIV;
        S_DIV: begin
          if (div_done && div_z_done) begin
            px     <= sat_x;
            pz     <= sat_z;
            pushed <= 1'b1;
            if (idx_inc == box_count) begin
              state <= S_EMIT;
            end else begin
              idx   <= idx_inc[AW-1:0];
              state <= S_READ;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            resolved_x     <= px;
            resolved_z     <= pz;
            any_push       <= pushed;
            table_overflow <= overflow_flag;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/cbcp_isqrt.sv */
// ---------------------------------------------------------------------------
// cbcp_isqrt: integer square root
// Floor square root of a 32-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module cbcp_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] rad;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [18:0] rem_s;
  logic [18:0] trial;
  logic        take;

  always_comb begin
    rem_s = {rem, rad[31:30]};
    trial = {1'b0, root, 2'b01};
    take  = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= 5'd16;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (run) begin
        rad <= {rad[29:0], 2'b00};
        if (take) begin
          rem  <= 17'(rem_s - trial);
          root <= {root[14:0], 1'b1};
        end else begin
          rem  <= rem_s[16:0];
          root <= {root[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/cbcp_div.sv */
// ---------------------------------------------------------------------------
// cbcp_div: signed by unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module cbcp_div #(
  parameter int NW = 34,
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   mag;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [CntW-1:0] cnt;
  logic            run;
  logic            neg;
  logic [DW:0]     rem_s;
  logic            take;

  always_comb begin
    rem_s = {rem, mag[NW-1]};
    take  = (rem_s >= {1'b0, dvs});
    quo   = neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CntW'(NW);
        neg <= num[NW-1];
        mag <= num[NW-1] ? NW'(-num) : NW'(num);
        dvs <= den;
        rem <= '0;
      end else if (run) begin
        if (take) begin
          rem <= DW'(rem_s - {1'b0, dvs});
        end else begin
          rem <= rem_s[DW-1:0];
        end
        mag <= {mag[NW-2:0], take};
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/cbcp_chk.sv */
// ---------------------------------------------------------------------------
// cbcp_chk: port checker
// Temporal checks on the top level ports, bound to the top level.
// ---------------------------------------------------------------------------
module cbcp_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] resolved_x,
  input logic signed [23:0] resolved_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(resolved_x) && $stable(resolved_z))
    else $error("stalled result changed or dropped");

  a_resolve_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == cbcp_pkg::OP_RESOLVE |=> !in_ready)
    else $error("input taken during a resolve");

  a_short_ops: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation != cbcp_pkg::OP_RESOLVE |=> in_ready)
    else $error("load or clear did not finish in one cycle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind circle_box_collision_pushout_top cbcp_chk u_cbcp_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .operation  (operation),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .resolved_x (resolved_x),
  .resolved_z (resolved_z)
);

/* bench/circle_box_collision_pushout_checker.sv */
// ---------------------------------------------------------------------------
// circle_box_collision_pushout_checker: result predictor and comparator
// Watches the input, output and register channels of the pushout block. It
// keeps its own box table and registers, predicts the resolved position for
// every resolve transaction, and compares results in order.
// ---------------------------------------------------------------------------
module circle_box_collision_pushout_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [23:0] box_min_x,
  input  logic signed [23:0] box_min_y,
  input  logic signed [23:0] box_min_z,
  input  logic signed [23:0] box_max_x,
  input  logic signed [23:0] box_max_y,
  input  logic signed [23:0] box_max_z,
  input  logic               box_solid,
  input  logic signed [23:0] player_x,
  input  logic signed [23:0] player_y,
  input  logic signed [23:0] player_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] resolved_x,
  input  logic signed [23:0] resolved_z,
  input  logic               any_push,
  input  logic               table_overflow,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_addr,
  input  logic [14:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int TableDepth = 1024;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
    logic               pushed;
    logic               overflow;
  } position_t;

  cbcp_pkg::box_t            box_table [TableDepth];
  int                        box_total;
  logic                      overflow_seen;
  logic [cbcp_pkg::RegW-1:0] radius;
  logic [cbcp_pkg::RegW-1:0] half_height;
  position_t                 expected_positions [$];

  assign pending_count = expected_positions.size();

  function automatic longint floor_root(longint unsigned n);
    longint unsigned res;
    longint unsigned bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos >>= 2;
    while (bitpos != 0) begin
      if (n >= res + bitpos) begin
        n -= res + bitpos;
        res = (res >> 1) + bitpos;
      end else begin
        res >>= 1;
      end
      bitpos >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint saturate(longint v);
    if (v > longint'(cbcp_pkg::CoordMax)) return longint'(cbcp_pkg::CoordMax);
    if (v < longint'(cbcp_pkg::CoordMin)) return longint'(cbcp_pkg::CoordMin);
    return v;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic position_t push_out(longint px, longint py, longint pz);
    position_t res;
    longint r, h, cx, cz, dx, dz, span, push, one;
    longint unsigned d2, r2;
    cbcp_pkg::box_t b;
    one = longint'(cbcp_pkg::One);
    r = longint'(radius);
    h = longint'(half_height);
    r2 = r * r;
    res.pushed = 1'b0;
    for (int i = 0; i < box_total; i++) begin
      b = box_table[i];
      if (b.solid) begin
        cx = clamp(px, longint'(b.min_x), longint'(b.max_x));
        cz = clamp(pz, longint'(b.min_z), longint'(b.max_z));
        dx = px - cx;
        dz = pz - cz;
        d2 = dx * dx + dz * dz;
        if (d2 < r2 && py - h < longint'(b.max_y) && py + h > longint'(b.min_y)) begin
          span = floor_root(d2);
          // A center inside the box has no direction; push along +x.
          if (span < longint'(cbcp_pkg::EpsDist)) begin
            dx = one;
            dz = 0;
            span = one;
          end
          push = r - span + longint'(cbcp_pkg::EpsPush);
          px = saturate(px + (dx * push) / span);
          pz = saturate(pz + (dz * push) / span);
          res.pushed = 1'b1;
        end
      end
    end
    res.pos_x = px[23:0];
    res.pos_z = pz[23:0];
    res.overflow = overflow_seen;
    return res;
  endfunction

  always @(posedge clk) begin
    position_t      want;
    cbcp_pkg::box_t b;
    if (rst) begin
      box_total <= 0;
      overflow_seen <= 1'b0;
      radius <= cbcp_pkg::RadiusReset;
      half_height <= cbcp_pkg::HalfHeightReset;
      fail_count <= 0;
      expected_positions.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transaction x=%0d z=%0d", resolved_x, resolved_z);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_positions.pop_front();
          if (want.pos_x !== resolved_x || want.pos_z !== resolved_z ||
              want.pushed !== any_push || want.overflow !== table_overflow) begin
            if (fail_count < 10)
              $display({"mismatch: expected x=%0d z=%0d push=%0b ovf=%0b, ",
                        "got x=%0d z=%0d push=%0b ovf=%0b"},
                       want.pos_x, want.pos_z, want.pushed, want.overflow,
                       resolved_x, resolved_z, any_push, table_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cbcp_pkg::reg_index_t'(cfg_addr))
          cbcp_pkg::REG_RADIUS:      radius <= cfg_data;
          cbcp_pkg::REG_HALF_HEIGHT: half_height <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (cbcp_pkg::op_t'(operation))
          cbcp_pkg::OP_LOAD: begin
            if (box_total >= TableDepth) begin
              overflow_seen <= 1'b1;
            end else begin
              b.min_x = box_min_x;
              b.min_y = box_min_y;
              b.min_z = box_min_z;
              b.max_x = box_max_x;
              b.max_y = box_max_y;
              b.max_z = box_max_z;
              b.solid = box_solid;
              box_table[box_total] <= b;
              box_total <= box_total + 1;
            end
          end
          cbcp_pkg::OP_RESOLVE:
            expected_positions.insert(expected_positions.size(),
                                      push_out(player_x, player_y, player_z));
          cbcp_pkg::OP_CLEAR: box_total <= 0;
          default: ;
        endcase
      end
    end
  end

endmodule

/* bench/circle_box_collision_pushout_top_test.sv */
// ---------------------------------------------------------------------------
// circle_box_collision_pushout_top_test: stimulus and verdict
// Drives directed and random load, resolve, clear and unused transactions with
// random idle bursts, rewrites the radius and half height between phases,
// and reports the checker's verdict.
// ---------------------------------------------------------------------------
module circle_box_collision_pushout_top_test;

  localparam int  TableDepth = 1024;
  localparam int  RandomItems = 140;
  localparam longint CycleLimit = 3000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = cbcp_pkg::OP_NONE;
  logic signed [23:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
  logic signed [23:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic               box_solid = 1'b0;
  logic signed [23:0] player_x = '0, player_y = '0, player_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] resolved_x, resolved_z;
  logic               any_push, table_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_addr = cbcp_pkg::REG_RADIUS;
  logic [14:0]        cfg_data = '0;
  int                 fail_count, pending_count;
  logic               quiet = 1'b0;
  int                 stall_left = 0;
  longint             cycle_count = 0;
  int                 boxes_held = 0;

  always #6 clk = ~clk;

  circle_box_collision_pushout_top u_top (.*);
  circle_box_collision_pushout_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result-side back pressure in short bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && !rst && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic signed [23:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return 24'($urandom());
    return 24'(int'($urandom_range(0, 65535)) - 32768);
  endfunction

  task automatic send(cbcp_pkg::op_t op, logic signed [23:0] mnx,
                      logic signed [23:0] mny,
                      logic signed [23:0] mnz, logic signed [23:0] mxx,
                      logic signed [23:0] mxy, logic signed [23:0] mxz, logic sol,
                      logic signed [23:0] px, logic signed [23:0] py,
                      logic signed [23:0] pz);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    box_min_x <= mnx; box_min_y <= mny; box_min_z <= mnz;
    box_max_x <= mxx; box_max_y <= mxy; box_max_z <= mxz;
    box_solid <= sol;
    player_x <= px; player_y <= py; player_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == cbcp_pkg::OP_LOAD && boxes_held < TableDepth) boxes_held++;
    if (op == cbcp_pkg::OP_CLEAR) boxes_held = 0;
  endtask

  task automatic load_box(logic signed [23:0] mnx, logic signed [23:0] mny,
                          logic signed [23:0] mnz, logic signed [23:0] mxx,
                          logic signed [23:0] mxy, logic signed [23:0] mxz, logic sol);
    send(cbcp_pkg::OP_LOAD, mnx, mny, mnz, mxx, mxy, mxz, sol, pick_coord(),
         pick_coord(), pick_coord());
  endtask

  task automatic resolve(logic signed [23:0] px, logic signed [23:0] py,
                         logic signed [23:0] pz);
    send(cbcp_pkg::OP_RESOLVE, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), pick_coord(), 1'($urandom()), px, py, pz);
  endtask

  task automatic send_other(cbcp_pkg::op_t op);
    send(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), 1'($urandom()), pick_coord(), pick_coord(), pick_coord());
  endtask

  // Registers change only with the block idle and all results drained.
  task automatic write_reg(cbcp_pkg::reg_index_t idx, logic [14:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_box();
    logic signed [23:0] ax, ay, az, bx, by, bz, t;
    ax = pick_coord(); ay = pick_coord(); az = pick_coord();
    bx = 24'(ax + $urandom_range(0, 16384));
    by = 24'(ay + $urandom_range(0, 32768));
    bz = 24'(az + $urandom_range(0, 16384));
    // Now and then an inverted box.
    if ($urandom_range(0, 9) == 0) begin
      t = ax; ax = bx; bx = t;
    end
    load_box(ax, ay, az, bx, by, bz, $urandom_range(0, 4) != 0);
  endtask

  task automatic random_phase(int count, bit last_phase);
    int pick;
    for (int n = 0; n < count; n++) begin
      // The tail of the run goes without idle cycles on either side.
      if (last_phase && n >= count - 15) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (boxes_held >= 8) begin
        resolve(pick_coord(), pick_coord(), pick_coord());
        send_other(cbcp_pkg::OP_CLEAR);
      end else if (pick < 45) random_box();
      else if (pick < 88) resolve(pick_coord(), pick_coord(), pick_coord());
      else if (pick < 95) send_other(cbcp_pkg::OP_CLEAR);
      else send_other(cbcp_pkg::OP_NONE);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with reset register values.
    resolve(24'sd0, 24'sd0, 24'sd0);
    load_box(cbcp_pkg::CoordMin, cbcp_pkg::CoordMin, cbcp_pkg::CoordMin,
             cbcp_pkg::CoordMax, cbcp_pkg::CoordMax, cbcp_pkg::CoordMax, 1'b1);
    resolve(cbcp_pkg::CoordMax, 24'sd0, cbcp_pkg::CoordMax);
    resolve(cbcp_pkg::CoordMin, cbcp_pkg::CoordMax, cbcp_pkg::CoordMin);
    send_other(cbcp_pkg::OP_CLEAR);
    load_box(24'sd8192, -24'sd4096, 24'sd8192, 24'sd0, 24'sd4096, 24'sd0, 1'b1);
    resolve(24'sd9000, 24'sd0, 24'sd8000);
    load_box(24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd4096, 24'sd4096, 1'b0);
    resolve(24'sd2000, 24'sd2000, 24'sd2000);
    load_box(24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd4096, 24'sd4096, 1'b1);
    resolve(24'sd5000, 24'sd2000, 24'sd4600);
    resolve(24'sd2000, 24'sd50000, 24'sd2000);
    send_other(cbcp_pkg::OP_NONE);
    resolve(-24'sd100, 24'sd0, 24'sd2000);
    send_other(cbcp_pkg::OP_CLEAR);
    load_box(24'sd8388000, 24'sd0, 24'sd0, cbcp_pkg::CoordMax, 24'sd4096, 24'sd4096,
             1'b1);
    resolve(24'sd8388300, 24'sd100, 24'sd2000);
    send_other(cbcp_pkg::OP_CLEAR);

    write_reg(cbcp_pkg::REG_RADIUS, 15'd1);
    write_reg(cbcp_pkg::REG_HALF_HEIGHT, 15'd0);
    random_phase(25, 1'b0);
    write_reg(cbcp_pkg::REG_RADIUS, 15'd32767);
    write_reg(cbcp_pkg::REG_HALF_HEIGHT, 15'd32767);
    random_phase(35, 1'b0);
    write_reg(cbcp_pkg::REG_RADIUS, 15'($urandom_range(2000, 20000)));
    write_reg(cbcp_pkg::REG_HALF_HEIGHT, 15'($urandom_range(1, 32766)));
    random_phase(30, 1'b0);

    write_reg(cbcp_pkg::REG_RADIUS, cbcp_pkg::RadiusReset);
    write_reg(cbcp_pkg::REG_HALF_HEIGHT, cbcp_pkg::HalfHeightReset);
    random_phase(RandomItems - 110, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
